// File: rtl/dual_incremental_pid_speed_defines.svh
// Assertion macros shared by the dual wheel PID speed controller checkers.
// No dependencies; include by bare file name.
`ifndef DUAL_INCREMENTAL_PID_SPEED_DEFINES_SVH
`define DUAL_INCREMENTAL_PID_SPEED_DEFINES_SVH

// Assertion that is off while reset is asserted.
`define DIPS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("dips: assertion failed");

// Assertion that is also checked across reset.
`define DIPS_ASSERT_ANY(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("dips: assertion failed");

`endif

// File: rtl/dips_pkg.sv
// Package for the dual wheel PID speed controller: payload and config types,
// register indexes and default parameters. No dependencies.
`timescale 1ns / 1ps

package dips_pkg;

    localparam int GAIN_FRAC_BITS_DEF = 8;
    localparam int DRIVE_MAX_DEF      = 500;
    localparam int DUTY_SCALE_DEF     = 20;

    localparam int DATA_W  = 16;
    localparam int ERR_W   = DATA_W + 1;
    localparam int DUTY_W  = 14;
    localparam int SUM_W   = 36;     // holds Kp*d1 + Ki*e0 + Kd*d2 exactly
    localparam int ADDR_W  = 5;
    localparam int IDX_W   = 3;
    localparam int APB_W   = 32;

    // register indexes (byte address = 4 * index)
    localparam logic [IDX_W-1:0] REG_TARGET_LEFT  = 3'd0;
    localparam logic [IDX_W-1:0] REG_TARGET_RIGHT = 3'd1;
    localparam logic [IDX_W-1:0] REG_P_GAIN_LEFT  = 3'd2;
    localparam logic [IDX_W-1:0] REG_I_GAIN_LEFT  = 3'd3;
    localparam logic [IDX_W-1:0] REG_D_GAIN_LEFT  = 3'd4;
    localparam logic [IDX_W-1:0] REG_P_GAIN_RIGHT = 3'd5;
    localparam logic [IDX_W-1:0] REG_I_GAIN_RIGHT = 3'd6;
    localparam logic [IDX_W-1:0] REG_D_GAIN_RIGHT = 3'd7;

    typedef struct packed {
        logic signed [DATA_W-1:0] speed_left;
        logic signed [DATA_W-1:0] speed_right;
    } t_in;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_left;
        logic [DUTY_W-1:0] duty_right;
    } t_out;

    typedef struct packed {
        logic signed [DATA_W-1:0] target_left;
        logic signed [DATA_W-1:0] target_right;
        logic signed [DATA_W-1:0] p_gain_left;
        logic signed [DATA_W-1:0] i_gain_left;
        logic signed [DATA_W-1:0] d_gain_left;
        logic signed [DATA_W-1:0] p_gain_right;
        logic signed [DATA_W-1:0] i_gain_right;
        logic signed [DATA_W-1:0] d_gain_right;
    } t_cfg;

    // pipeline advance strobes handed to each wheel lane
    typedef struct packed {
        logic load_b;   // input register -> product register
        logic load_c;   // product register -> result register
    } t_pipe_ctl;

endpackage

// File: rtl/dual_incremental_pid_speed.sv
// Top level of the dual wheel incremental PID speed controller.
// Depends on dips_pkg, dips_regs and dips_wheel.
`timescale 1ns / 1ps

// Usage
//  - Input channel (i_valid / o_ready, i_data): one request per control tick,
//    carrying the measured left and right wheel speeds.
//  - Output channel (o_valid / i_ready, o_data): one result per request, the
//    left and right PWM duty (drive * DUTY_SCALE, or 0 for both when both
//    targets are zero).
//  - APB port: targets and Q8.8 gains at byte address 4 * index. The user
//    must have them written only while no request is in flight; the block
//    does not enforce this. pready is tied high.
//  - o_valid rises once a request has passed the input, product and result
//    registers. Throughput: one request per cycle unless the receiver
//    stalls, set by the three-stage pipeline; the error history is updated
//    in the product stage and the drive accumulator in the result stage, so
//    consecutive requests see each other's state without bubbles.
//  - Reset (synchronous, active low) clears config, error history, drive
//    accumulators and all valid flags; o_ready is low during reset.
//  - When the receiver stalls, each stage holds once the one ahead is full;
//    with all three full, o_ready drops until a result is taken.

module dual_incremental_pid_speed #(
    parameter int GAIN_FRAC_BITS = dips_pkg::GAIN_FRAC_BITS_DEF,
    parameter int DRIVE_MAX      = dips_pkg::DRIVE_MAX_DEF,
    parameter int DUTY_SCALE     = dips_pkg::DUTY_SCALE_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // request channel
    input  logic                         i_valid,
    output logic                         o_ready,
    input  dips_pkg::t_in                i_data,
    // result channel
    output logic                         o_valid,
    input  logic                         i_ready,
    output dips_pkg::t_out               o_data,
    // APB config
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dips_pkg::ADDR_W-1:0]  paddr,
    input  logic [dips_pkg::APB_W-1:0]   pwdata,
    output logic [dips_pkg::APB_W-1:0]   prdata,
    output logic                         pready
);

    dips_pkg::t_cfg      cfg;
    dips_pkg::t_pipe_ctl ctl;

    // pipeline valid flags: A = input reg, B = products, C = result
    logic r_a_valid, r_b_valid, r_c_valid;
    logic n_a_valid, n_b_valid, n_c_valid;
    dips_pkg::t_in r_in;
    logic r_stop;

    logic accept, a_free, b_free, c_free;
    logic [dips_pkg::DUTY_W-1:0] duty_l, duty_r;

    dips_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (cfg)
    );

    // ready chain: a stage may load when it is empty or moving forward
    assign c_free     = !r_c_valid || i_ready;
    assign ctl.load_c = r_b_valid && c_free;
    assign b_free     = !r_b_valid || ctl.load_c;
    assign ctl.load_b = r_a_valid && b_free;
    assign a_free     = !r_a_valid || ctl.load_b;
    assign o_ready    = a_free && i_rst_n;
    assign accept     = i_valid && o_ready;

    assign n_a_valid = accept || (r_a_valid && !ctl.load_b);
    assign n_b_valid = ctl.load_b || (r_b_valid && !ctl.load_c);
    assign n_c_valid = ctl.load_c || (r_c_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            r_a_valid <= n_a_valid;
            r_b_valid <= n_b_valid;
            r_c_valid <= n_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_data;
        end
        if (ctl.load_c) begin
            // both targets zero forces both duties to zero
            r_stop <= (cfg.target_left == '0) && (cfg.target_right == '0);
        end
    end

    dips_wheel #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .DRIVE_MAX      (DRIVE_MAX),
        .DUTY_SCALE     (DUTY_SCALE)
    ) u_left (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_target (cfg.target_left),
        .i_kp     (cfg.p_gain_left),
        .i_ki     (cfg.i_gain_left),
        .i_kd     (cfg.d_gain_left),
        .i_speed  (r_in.speed_left),
        .o_duty   (duty_l)
    );

    dips_wheel #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .DRIVE_MAX      (DRIVE_MAX),
        .DUTY_SCALE     (DUTY_SCALE)
    ) u_right (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_target (cfg.target_right),
        .i_kp     (cfg.p_gain_right),
        .i_ki     (cfg.i_gain_right),
        .i_kd     (cfg.d_gain_right),
        .i_speed  (r_in.speed_right),
        .o_duty   (duty_r)
    );

    assign o_valid           = r_c_valid;
    assign o_data.duty_left  = r_stop ? '0 : duty_l;
    assign o_data.duty_right = r_stop ? '0 : duty_r;

endmodule

// File: rtl/dips_regs.sv
// APB configuration registers of the dual wheel PID speed controller.
// Depends on dips_pkg.
`timescale 1ns / 1ps

module dips_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic [dips_pkg::ADDR_W-1:0]  i_paddr,
    input  logic [dips_pkg::APB_W-1:0]   i_pwdata,
    output logic [dips_pkg::APB_W-1:0]   o_prdata,
    output logic                         o_pready,
    output dips_pkg::t_cfg               o_cfg
);

    dips_pkg::t_cfg                   r_cfg;
    logic                             wr_en;
    logic [dips_pkg::IDX_W-1:0]       idx;
    logic signed [dips_pkg::DATA_W-1:0] wdat;
    logic signed [dips_pkg::DATA_W-1:0] rdat;

    assign o_pready = 1'b1;
    assign wr_en    = i_psel && i_penable && i_pwrite;
    assign idx      = i_paddr[dips_pkg::IDX_W+1:2];
    assign wdat     = i_pwdata[dips_pkg::DATA_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            case (idx)
                dips_pkg::REG_TARGET_LEFT:  r_cfg.target_left  <= wdat;
                dips_pkg::REG_TARGET_RIGHT: r_cfg.target_right <= wdat;
                dips_pkg::REG_P_GAIN_LEFT:  r_cfg.p_gain_left  <= wdat;
                dips_pkg::REG_I_GAIN_LEFT:  r_cfg.i_gain_left  <= wdat;
                dips_pkg::REG_D_GAIN_LEFT:  r_cfg.d_gain_left  <= wdat;
                dips_pkg::REG_P_GAIN_RIGHT: r_cfg.p_gain_right <= wdat;
                dips_pkg::REG_I_GAIN_RIGHT: r_cfg.i_gain_right <= wdat;
                dips_pkg::REG_D_GAIN_RIGHT: r_cfg.d_gain_right <= wdat;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            dips_pkg::REG_TARGET_LEFT:  rdat = r_cfg.target_left;
            dips_pkg::REG_TARGET_RIGHT: rdat = r_cfg.target_right;
            dips_pkg::REG_P_GAIN_LEFT:  rdat = r_cfg.p_gain_left;
            dips_pkg::REG_I_GAIN_LEFT:  rdat = r_cfg.i_gain_left;
            dips_pkg::REG_D_GAIN_LEFT:  rdat = r_cfg.d_gain_left;
            dips_pkg::REG_P_GAIN_RIGHT: rdat = r_cfg.p_gain_right;
            dips_pkg::REG_I_GAIN_RIGHT: rdat = r_cfg.i_gain_right;
            dips_pkg::REG_D_GAIN_RIGHT: rdat = r_cfg.d_gain_right;
            default:                    rdat = '0;
        endcase
    end

    // sign-extended readback
    assign o_prdata = dips_pkg::APB_W'(rdat);
    assign o_cfg    = r_cfg;

endmodule

// File: rtl/dips_wheel.sv
// One wheel lane: error history, gain products, drive accumulator and duty.
// Depends on dips_pkg; advanced by the pipeline strobes of the top level.
`timescale 1ns / 1ps

module dips_wheel #(
    parameter int GAIN_FRAC_BITS = dips_pkg::GAIN_FRAC_BITS_DEF,
    parameter int DRIVE_MAX      = dips_pkg::DRIVE_MAX_DEF,
    parameter int DUTY_SCALE     = dips_pkg::DUTY_SCALE_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  dips_pkg::t_pipe_ctl                i_ctl,
    input  logic signed [dips_pkg::DATA_W-1:0] i_target,
    input  logic signed [dips_pkg::DATA_W-1:0] i_kp,
    input  logic signed [dips_pkg::DATA_W-1:0] i_ki,
    input  logic signed [dips_pkg::DATA_W-1:0] i_kd,
    input  logic signed [dips_pkg::DATA_W-1:0] i_speed,
    output logic [dips_pkg::DUTY_W-1:0]        o_duty
);

    localparam int ERR_W   = dips_pkg::ERR_W;
    localparam int DP_W    = ERR_W + 1;              // e0 - e1
    localparam int DD_W    = ERR_W + 2;              // e0 - 2*e1 + e2
    localparam int PP_W    = dips_pkg::DATA_W + DP_W;
    localparam int PI_W    = dips_pkg::DATA_W + ERR_W;
    localparam int PD_W    = dips_pkg::DATA_W + DD_W;
    localparam int SUM_W   = dips_pkg::SUM_W;
    localparam int ACC_W   = SUM_W + 1;
    localparam int DRV_W   = $clog2(DRIVE_MAX + 1);
    localparam int DPROD_W = (DRV_W + 8 > dips_pkg::DUTY_W) ? DRV_W + 8 : dips_pkg::DUTY_W;

    localparam logic signed [SUM_W-1:0] BIAS  = SUM_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);
    localparam logic signed [ACC_W-1:0] MAX_S = ACC_W'(DRIVE_MAX);

    logic signed [ERR_W-1:0]  r_e1, r_e2;
    logic signed [PP_W-1:0]   r_pp;
    logic signed [PI_W-1:0]   r_pi;
    logic signed [PD_W-1:0]   r_pd;
    logic [DRV_W-1:0]         r_drive, n_drive;
    logic [dips_pkg::DUTY_W-1:0] r_duty, n_duty;

    logic signed [ERR_W-1:0]  e0;
    logic signed [DP_W-1:0]   d_p;
    logic signed [DD_W-1:0]   d_d;
    logic signed [PP_W-1:0]   m_p;
    logic signed [PI_W-1:0]   m_i;
    logic signed [PD_W-1:0]   m_d;
    logic signed [SUM_W-1:0]  sum, rnd, inc;
    logic signed [ACC_W-1:0]  acc;
    logic [DPROD_W-1:0]       duty_full;

    // stage A: error terms and the three gain products
    assign e0  = ERR_W'(i_target) - ERR_W'(i_speed);
    assign d_p = DP_W'(e0) - DP_W'(r_e1);
    assign d_d = DD_W'(e0) - (DD_W'(r_e1) <<< 1) + DD_W'(r_e2);
    assign m_p = i_kp * d_p;
    assign m_i = i_ki * e0;
    assign m_d = i_kd * d_d;

    // stage B: sum, truncate toward zero, accumulate and clamp
    assign sum = SUM_W'(r_pp) + SUM_W'(r_pi) + SUM_W'(r_pd);
    assign rnd = sum + (sum[SUM_W-1] ? BIAS : '0);
    assign inc = rnd >>> GAIN_FRAC_BITS;
    assign acc = ACC_W'(signed'({1'b0, r_drive})) + ACC_W'(inc);

    always_comb begin
        if (acc >= MAX_S) begin
            n_drive = DRV_W'(DRIVE_MAX);
        end else if (acc < 0) begin
            n_drive = '0;
        end else begin
            n_drive = acc[DRV_W-1:0];
        end
    end

    assign duty_full = DPROD_W'(n_drive) * DPROD_W'(DUTY_SCALE);
    assign n_duty    = duty_full[dips_pkg::DUTY_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1    <= '0;
            r_e2    <= '0;
            r_drive <= '0;
        end else begin
            if (i_ctl.load_b) begin
                r_e1 <= e0;
                r_e2 <= r_e1;
            end
            if (i_ctl.load_c) begin
                r_drive <= n_drive;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_b) begin
            r_pp <= m_p;
            r_pi <= m_i;
            r_pd <= m_d;
        end
        if (i_ctl.load_c) begin
            r_duty <= n_duty;
        end
    end

    assign o_duty = r_duty;

endmodule

// File: rtl/dips_checker.sv
// Port-level checker for the dual wheel PID speed controller, bound to the
// top level. Depends on dips_pkg and dual_incremental_pid_speed_defines.svh.
`timescale 1ns / 1ps
`include "dual_incremental_pid_speed_defines.svh"

module dips_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_valid,
    input logic           o_ready,
    input logic           o_valid,
    input logic           i_ready,
    input dips_pkg::t_out o_data
);

    // reset empties the pipeline
    `DIPS_ASSERT_ANY(a_rst_empty, i_clk, !i_rst_n |=> !o_valid)

    // backpressure only when all three stages are full and stalled
    `DIPS_ASSERT(a_full_stall, i_clk, i_rst_n, !o_ready |-> (o_valid && !i_ready))

    // from an empty output, a rising result was accepted and passed the input, product and result registers
    `DIPS_ASSERT(a_latency, i_clk, i_rst_n, $rose(o_valid) |-> $past(i_valid && o_ready, 3))

    // a stalled result holds
    `DIPS_ASSERT(a_hold, i_clk, i_rst_n, (o_valid && !i_ready) |=> (o_valid && $stable(o_data)))

endmodule

bind dual_incremental_pid_speed dips_checker u_dips_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);

// File: bench/tb_top.sv
// Testbench for dual_incremental_pid_speed: drives wheel speed requests and APB config,
// predicts both PID loops in SystemVerilog and checks every duty result in order.
// Depends on dips_pkg and the dual_incremental_pid_speed RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int     CLK_PERIOD  = 20;
    localparam int     DATA_W      = dips_pkg::DATA_W;
    localparam int     IDX_W       = dips_pkg::IDX_W;
    localparam int     ADDR_W      = dips_pkg::ADDR_W;
    localparam int     APB_W       = dips_pkg::APB_W;
    localparam int     DUTY_W      = dips_pkg::DUTY_W;
    localparam longint GAIN_DIV    = longint'(1) << dips_pkg::GAIN_FRAC_BITS_DEF;
    localparam longint DRIVE_LIMIT = dips_pkg::DRIVE_MAX_DEF;
    localparam longint DUTY_MULT   = dips_pkg::DUTY_SCALE_DEF;
    localparam longint DUTY_MASK   = (longint'(1) << DUTY_W) - 1;

    typedef enum {PH_TRACK, PH_WILD, PH_STOPPED, PH_EDGE} t_phase_kind;

    // per-wheel loop state: previous error, the one before it, drive accumulator
    typedef struct {
        longint last_err;
        longint older_err;
        longint drive;
    } t_wheel;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    dips_pkg::t_in     i_data  = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    dips_pkg::t_out    o_data;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [APB_W-1:0]  pwdata  = '0;
    logic [APB_W-1:0]  prdata;
    logic              pready;

    dual_incremental_pid_speed uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // shadow of the config registers and the loop state
    dips_pkg::t_cfg cfg     = '0;
    t_wheel         left_w  = '{0, 0, 0};
    t_wheel         right_w = '{0, 0, 0};

    dips_pkg::t_in  speed_q[$];   // requests waiting to be driven
    dips_pkg::t_out duty_q[$];    // predicted duties, oldest first

    int   mismatches = 0;
    bit   in_taken   = 1'b0;
    bit   out_taken  = 1'b0;
    int   send_wait  = 0;
    int   ready_wait = 0;
    bit   no_gap     = 1'b0;
    bit   no_stall   = 1'b0;
    dips_pkg::t_out want;

    // one velocity-form PID update; truncating division matches the shift toward zero
    function automatic void wheel_tick(inout t_wheel w, input longint target, input longint speed,
                                       input longint kp, input longint ki, input longint kd);
        longint e0;
        longint s;
        longint d;
        e0 = target - speed;
        s  = kp * (e0 - w.last_err) + ki * e0 + kd * (e0 - 2 * w.last_err + w.older_err);
        w.older_err = w.last_err;
        w.last_err  = e0;
        d = w.drive + s / GAIN_DIV;
        if (d >= DRIVE_LIMIT) begin
            d = DRIVE_LIMIT;
        end else if (d < 0) begin
            d = 0;
        end
        w.drive = d;
    endfunction

    function automatic dips_pkg::t_out pid_tick(input dips_pkg::t_in sp);
        dips_pkg::t_out r;
        longint         dl;
        longint         dr;
        wheel_tick(right_w, cfg.target_right, sp.speed_right,
                   cfg.p_gain_right, cfg.i_gain_right, cfg.d_gain_right);
        wheel_tick(left_w, cfg.target_left, sp.speed_left,
                   cfg.p_gain_left, cfg.i_gain_left, cfg.d_gain_left);
        dl = (left_w.drive * DUTY_MULT) & DUTY_MASK;
        dr = (right_w.drive * DUTY_MULT) & DUTY_MASK;
        r.duty_left  = dl[DUTY_W-1:0];
        r.duty_right = dr[DUTY_W-1:0];
        // both targets zero: motors stopped, state still moves
        if (cfg.target_left == 0 && cfg.target_right == 0) begin
            r = '0;
        end
        return r;
    endfunction

    // request driver: holds valid until taken, then idles until the random send_wait count runs out
    always @(negedge i_clk) begin
        if (!i_valid || in_taken) begin
            if (i_valid) begin
                send_wait = no_gap ? 0 : $urandom_range(0, 5);
            end
            if (send_wait > 0) begin
                i_valid <= 1'b0;
                send_wait--;
            end else if (speed_q.size() != 0) begin
                i_data  <= speed_q.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result receiver: after each result, drops ready until the random ready_wait count runs out
    always @(negedge i_clk) begin
        if (out_taken) begin
            ready_wait = no_stall ? 0 : $urandom_range(0, 5);
        end
        if (ready_wait > 0) begin
            i_ready <= 1'b0;
            ready_wait--;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // monitor: predict on accepted request, check on accepted result
    always @(posedge i_clk) begin
        in_taken  <= i_valid && o_ready;
        out_taken <= o_valid && i_ready;
        if (i_valid && o_ready) begin
            duty_q.push_back(pid_tick(i_data));
        end
        if (o_valid && i_ready) begin
            if (duty_q.size() == 0) begin
                $error("unexpected result: duty_left %0d duty_right %0d",
                       o_data.duty_left, o_data.duty_right);
                mismatches++;
            end else begin
                want = duty_q.pop_front();
                if (o_data.duty_left !== want.duty_left) begin
                    $error("duty_left expected %0d actual %0d", want.duty_left, o_data.duty_left);
                    mismatches++;
                end
                if (o_data.duty_right !== want.duty_right) begin
                    $error("duty_right expected %0d actual %0d",
                           want.duty_right, o_data.duty_right);
                    mismatches++;
                end
            end
        end
    end

    // APB write: setup cycle, access cycle, then release
    task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic signed [DATA_W-1:0] v);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = {{(APB_W - DATA_W){v[DATA_W-1]}}, v};
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            dips_pkg::REG_TARGET_LEFT:  cfg.target_left  = v;
            dips_pkg::REG_TARGET_RIGHT: cfg.target_right = v;
            dips_pkg::REG_P_GAIN_LEFT:  cfg.p_gain_left  = v;
            dips_pkg::REG_I_GAIN_LEFT:  cfg.i_gain_left  = v;
            dips_pkg::REG_D_GAIN_LEFT:  cfg.d_gain_left  = v;
            dips_pkg::REG_P_GAIN_RIGHT: cfg.p_gain_right = v;
            dips_pkg::REG_I_GAIN_RIGHT: cfg.i_gain_right = v;
            dips_pkg::REG_D_GAIN_RIGHT: cfg.d_gain_right = v;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic signed [DATA_W-1:0] tl, input logic signed [DATA_W-1:0] tr,
                              input logic signed [DATA_W-1:0] pl, input logic signed [DATA_W-1:0] il,
                              input logic signed [DATA_W-1:0] dl, input logic signed [DATA_W-1:0] pr,
                              input logic signed [DATA_W-1:0] ir, input logic signed [DATA_W-1:0] dr);
        cfg_write(dips_pkg::REG_TARGET_LEFT, tl);
        cfg_write(dips_pkg::REG_TARGET_RIGHT, tr);
        cfg_write(dips_pkg::REG_P_GAIN_LEFT, pl);
        cfg_write(dips_pkg::REG_I_GAIN_LEFT, il);
        cfg_write(dips_pkg::REG_D_GAIN_LEFT, dl);
        cfg_write(dips_pkg::REG_P_GAIN_RIGHT, pr);
        cfg_write(dips_pkg::REG_I_GAIN_RIGHT, ir);
        cfg_write(dips_pkg::REG_D_GAIN_RIGHT, dr);
    endtask

    task automatic add_speed(input logic signed [DATA_W-1:0] sl, input logic signed [DATA_W-1:0] sr);
        dips_pkg::t_in sp;
        sp.speed_left  = sl;
        sp.speed_right = sr;
        speed_q.push_back(sp);
    endtask

    // wait until every request is in and every result out, then let the pipe empty
    task automatic settle();
        while (speed_q.size() != 0 || i_valid || duty_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (6) @(posedge i_clk);
    endtask

    function automatic logic signed [DATA_W-1:0] near(input int span);
        return DATA_W'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic logic signed [DATA_W-1:0] edge_pick();
        case ($urandom_range(0, 5))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return '0;
            3:       return -16'sd1;
            4:       return 16'sd1;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    initial begin
        t_phase_kind              kind;
        int                       count;
        logic signed [DATA_W-1:0] v[8];
        dips_pkg::t_in            sp;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // targets zero: duties stay 0 while the accumulators still run
        set_config(16'sd0, 16'sd0, 16'sd256, 16'sd128, 16'sd64, 16'sd256, 16'sd128, 16'sd64);
        add_speed(16'sd0, 16'sd0);
        add_speed(16'sh7FFF, 16'sh8000);
        add_speed(16'sh8000, 16'sh7FFF);
        add_speed(16'sd100, -16'sd100);
        settle();

        // nonzero targets: zero error, both directions of error, drive pinned high and low
        set_config(16'sd1000, -16'sd1000, 16'sd256, 16'sd128, 16'sd64,
                   16'sd256, 16'sd128, 16'sd64);
        add_speed(16'sd1000, -16'sd1000);
        add_speed(16'sd0, 16'sd0);
        add_speed(16'sh8000, 16'sh7FFF);
        add_speed(16'sh7FFF, 16'sh8000);
        add_speed(16'sd1000, -16'sd1000);
        add_speed(16'sd990, -16'sd1010);
        settle();

        // extreme gains and targets against extreme speeds
        set_config(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
                   16'sh8000, 16'sh7FFF, 16'sh8000);
        add_speed(16'sh8000, 16'sh7FFF);
        add_speed(16'sh7FFF, 16'sh8000);
        add_speed(16'sd0, 16'sd0);
        add_speed(16'sh8000, 16'sh8000);
        add_speed(16'sh7FFF, 16'sh7FFF);
        settle();

        // one target zero only: duties are not forced
        set_config(16'sd0, 16'sd5, 16'sd512, 16'sd256, -16'sd256,
                   16'sd512, 16'sd256, -16'sd256);
        add_speed(16'sd3, 16'sd0);
        add_speed(-16'sd7, 16'sd2);
        add_speed(16'sd0, 16'sd5);
        add_speed(16'sd1, 16'sd9);
        settle();

        // random phases
        for (int ph = 0; ph < 24; ph++) begin
            kind     = t_phase_kind'($urandom_range(0, 3));
            no_gap   = ($urandom_range(0, 3) == 0);
            no_stall = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < 8; k++) begin
                case (kind)
                    PH_TRACK:   v[k] = (k < 2) ? near(2000) : near(768);
                    PH_WILD:    v[k] = DATA_W'($urandom);
                    PH_STOPPED: v[k] = (k < 2) ? 16'sd0 : near(768);
                    default:    v[k] = edge_pick();
                endcase
            end
            if (kind == PH_TRACK && $urandom_range(0, 7) == 0) begin
                v[$urandom_range(0, 1)] = '0;
            end
            set_config(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
            count = $urandom_range(60, 100);
            for (int n = 0; n < count; n++) begin
                sp = dips_pkg::t_in'($urandom);
                // track phases: speeds hover around the targets so drive stays off the rails
                if (kind == PH_TRACK && $urandom_range(0, 9) != 0) begin
                    sp.speed_left  = cfg.target_left + near(64);
                    sp.speed_right = cfg.target_right + near(64);
                end
                speed_q.push_back(sp);
            end
            settle();
        end

        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS dual_incremental_pid_speed");
        end else begin
            $display("FAIL dual_incremental_pid_speed");
        end
        $finish;
    end

    initial begin
        #(CLK_PERIOD * 400000);
        $display("FAIL dual_incremental_pid_speed");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/dips_pkg.sv
rtl/dips_regs.sv
rtl/dips_wheel.sv
rtl/dual_incremental_pid_speed.sv
rtl/dips_checker.sv
bench/tb_top.sv
